// ----- rtl/ghal_pkg.sv -----
package ghal_pkg;

    localparam int SLOTS  = 64;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int GEN_W  = 8;
    localparam int HDL_W  = 16;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 48;
    localparam int TBL_W  = GEN_W + 1;

    localparam logic [7:0] SLOTS_B = 8'(SLOTS);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_STALE   = 2'd2;

    typedef enum logic [1:0] {
        CMD_CREATE     = 2'd0,
        CMD_LOOKUP     = 2'd1,
        CMD_REMOVE     = 2'd2,
        CMD_REMOVE_ALL = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // input transaction accepted this cycle
        logic slot_load;  // latch popped slot, read its table entry
        logic scan_rd;    // read table entry at scan index
        logic scan_chk;   // free scanned entry if live, step index down
        logic commit;     // apply writes, load result register
    } ghal_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t in_cmd;
        logic out_free;
        logic scan_last;
    } ghal_sts_t;

endpackage

// ----- rtl/ghal_ram.sv -----
module ghal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ghal_ctrl.sv -----
module ghal_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ghal_pkg::ghal_sts_t sts,
    output ghal_pkg::ghal_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_C_TBL,
        S_RA_RD,
        S_RA_CHK,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd           = '0;
        s_tready      = (state_reg == S_IDLE);
        cmd.take      = (state_reg == S_IDLE) && s_tvalid;
        cmd.slot_load = (state_reg == S_C_TBL);
        cmd.scan_rd   = (state_reg == S_RA_RD);
        cmd.scan_chk  = (state_reg == S_RA_CHK);
        cmd.commit    = (state_reg == S_FIN) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (sts.in_cmd)
                        ghal_pkg::CMD_CREATE:     state_next = S_C_TBL;
                        ghal_pkg::CMD_LOOKUP:     state_next = S_FIN;
                        ghal_pkg::CMD_REMOVE:     state_next = S_FIN;
                        ghal_pkg::CMD_REMOVE_ALL: state_next = S_RA_RD;
                        default:                  state_next = S_IDLE;
                    endcase
                end
            end
            S_C_TBL:  state_next = S_FIN;
            S_RA_RD:  state_next = S_RA_CHK;
            S_RA_CHK: state_next = sts.scan_last ? S_FIN : S_RA_RD;
            S_FIN:    state_next = sts.out_free ? S_IDLE : S_FIN;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_scan_walks : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RA_CHK && !sts.scan_last) |=> (state_reg == S_RA_RD))
        else $error("scan left before reaching slot zero");

endmodule

// ----- rtl/ghal_dp.sv -----
module ghal_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ghal_pkg::IN_W-1:0]    s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ghal_pkg::OUT_W-1:0]   m_tdata,
    input  ghal_pkg::ghal_cmd_t          cmd,
    output ghal_pkg::ghal_sts_t          sts
);

    localparam int SW = ghal_pkg::SLOT_W;
    localparam int GW = ghal_pkg::GEN_W;

    // held operation
    ghal_pkg::cmd_t              op_reg;
    logic [ghal_pkg::HDL_W-1:0]  hdl_reg;
    logic [7:0]                  slot_reg;
    logic [SW-1:0]               scan_reg;
    logic [SW-1:0]               rem_reg;

    // pool state
    logic [SW-1:0]               fc_reg;
    logic [SW-1:0]               fc_next;
    logic [SW-1:0]               live_reg;
    logic [SW-1:0]               live_next;
    logic [ghal_pkg::SLOTS-1:0]  tbl_vld_reg;
    logic [ghal_pkg::SLOTS-1:0]  stk_vld_reg;
    logic [SW-1:0]               tbl_ra_reg;
    logic [SW-1:0]               stk_ra_reg;

    // result register
    logic                        out_valid_reg;
    logic [1:0]                  st_reg;
    logic [ghal_pkg::HDL_W-1:0]  hout_reg;
    logic [7:0]                  sout_reg;
    logic [7:0]                  lout_reg;
    logic [7:0]                  rout_reg;

    logic [1:0]                  st_next;
    logic [ghal_pkg::HDL_W-1:0]  hout_next;
    logic [7:0]                  sout_next;
    logic [7:0]                  rout_next;

    // memory ports
    logic                        tbl_re;
    logic [SW-1:0]               tbl_ra;
    logic                        tbl_we;
    logic [ghal_pkg::TBL_W-1:0]  tbl_wd;
    logic [ghal_pkg::TBL_W-1:0]  tbl_rd;
    logic                        stk_re;
    logic                        push;
    logic [7:0]                  stk_rd;

    // decoded read data
    logic                        tbl_live;
    logic [GW-1:0]               tbl_gen;
    logic [GW-1:0]               gen_new;
    logic [7:0]                  stk_slot;
    logic [7:0]                  h_slot;
    logic                        match;
    logic                        create_ok;
    logic                        out_free;
    logic                        is_create;
    logic                        is_remove;

    assign out_free = !out_valid_reg || m_tready;

    assign sts.in_cmd    = ghal_pkg::cmd_t'(s_tdata[1:0]);
    assign sts.out_free  = out_free;
    assign sts.scan_last = (scan_reg == '0);

    // entries never written read as their reset values
    assign tbl_live = tbl_vld_reg[tbl_ra_reg] & tbl_rd[GW];
    assign tbl_gen  = tbl_vld_reg[tbl_ra_reg] ? tbl_rd[GW-1:0]
                    : GW'(tbl_ra_reg) + GW'(1);
    assign gen_new  = tbl_gen + 1'b1;
    assign stk_slot = stk_vld_reg[stk_ra_reg] ? stk_rd
                    : 8'(ghal_pkg::SLOTS - 1) - 8'(stk_ra_reg);

    assign h_slot    = hdl_reg[15:8];
    assign match     = (h_slot != 8'd0) && (h_slot < ghal_pkg::SLOTS_B) && tbl_live
                     && (tbl_gen == hdl_reg[7:0]);
    assign create_ok = (fc_reg != '0) && (slot_reg != 8'd0)
                     && (slot_reg < ghal_pkg::SLOTS_B);

    assign is_create = (op_reg == ghal_pkg::CMD_CREATE);
    assign is_remove = (op_reg == ghal_pkg::CMD_REMOVE);

    // table read address
    always_comb
    begin
        tbl_re = cmd.take || cmd.slot_load || cmd.scan_rd;
        priority if (cmd.take)
        begin
            tbl_ra = SW'(s_tdata[17:10]);
        end
        else if (cmd.slot_load)
        begin
            tbl_ra = SW'(stk_slot);
        end
        else
        begin
            tbl_ra = scan_reg;
        end
    end

    assign stk_re = cmd.take && (sts.in_cmd == ghal_pkg::CMD_CREATE);

    // every table write hits the table entry read just before
    assign tbl_we = (cmd.commit && is_create && create_ok)
                  || (cmd.commit && is_remove && match)
                  || (cmd.scan_chk && tbl_live);
    assign tbl_wd = is_create ? {1'b1, gen_new} : {1'b0, tbl_gen};
    assign push   = (cmd.commit && is_remove && match) || (cmd.scan_chk && tbl_live);

    always_comb
    begin
        fc_next   = fc_reg;
        live_next = live_reg;
        if (cmd.commit && is_create && create_ok)
        begin
            fc_next   = fc_reg - 1'b1;
            live_next = live_reg + 1'b1;
        end
        if (push)
        begin
            fc_next = fc_reg + 1'b1;
            if (live_reg != '0)
            begin
                live_next = live_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        st_next   = ghal_pkg::ST_OK;
        hout_next = '0;
        sout_next = 8'd0;
        rout_next = 8'd0;
        unique case (op_reg)
            ghal_pkg::CMD_CREATE:
            begin
                if (create_ok)
                begin
                    hout_next = {slot_reg, gen_new};
                    sout_next = slot_reg;
                end
                else
                begin
                    st_next = ghal_pkg::ST_NO_FREE;
                end
            end
            ghal_pkg::CMD_LOOKUP, ghal_pkg::CMD_REMOVE:
            begin
                if (match)
                begin
                    sout_next = h_slot;
                    rout_next = is_remove ? 8'd1 : 8'd0;
                end
                else
                begin
                    st_next = ghal_pkg::ST_STALE;
                end
            end
            ghal_pkg::CMD_REMOVE_ALL:
            begin
                rout_next = 8'(rem_reg);
            end
            default:
            begin
                st_next = ghal_pkg::ST_STALE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg        <= SW'(ghal_pkg::SLOTS - 1);
            live_reg      <= '0;
            tbl_vld_reg   <= '0;
            stk_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fc_reg   <= fc_next;
            live_reg <= live_next;
            if (tbl_we)
            begin
                tbl_vld_reg[tbl_ra_reg] <= 1'b1;
            end
            if (push)
            begin
                stk_vld_reg[fc_reg] <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg   <= sts.in_cmd;
            hdl_reg  <= s_tdata[17:2];
            scan_reg <= SW'(ghal_pkg::SLOTS - 1);
            rem_reg  <= '0;
        end
        if (cmd.slot_load)
        begin
            slot_reg <= stk_slot;
        end
        if (cmd.scan_chk)
        begin
            scan_reg <= scan_reg - 1'b1;
            if (tbl_live)
            begin
                rem_reg <= rem_reg + 1'b1;
            end
        end
        if (tbl_re)
        begin
            tbl_ra_reg <= tbl_ra;
        end
        if (stk_re)
        begin
            stk_ra_reg <= fc_reg - 1'b1;
        end
        if (cmd.commit)
        begin
            st_reg   <= st_next;
            hout_reg <= hout_next;
            sout_reg <= sout_next;
            lout_reg <= 8'(live_next);
            rout_reg <= rout_next;
        end
    end

    ghal_ram #(
        .WIDTH (ghal_pkg::TBL_W),
        .DEPTH (ghal_pkg::SLOTS)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_ra_reg),
        .wdata (tbl_wd),
        .re    (tbl_re),
        .raddr (tbl_ra),
        .rdata (tbl_rd)
    );

    ghal_ram #(
        .WIDTH (8),
        .DEPTH (ghal_pkg::SLOTS)
    ) u_stk (
        .clk   (clk),
        .we    (push),
        .waddr (fc_reg),
        .wdata (8'(tbl_ra_reg)),
        .re    (stk_re),
        .raddr (fc_reg - 1'b1),
        .rdata (stk_rd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, rout_reg, lout_reg, sout_reg, hout_reg, st_reg};

    a_pool_conserved : assert property (@(posedge clk) disable iff (!rst_n)
        ((SW+1)'(fc_reg) + (SW+1)'(live_reg)) == (SW+1)'(ghal_pkg::SLOTS - 1))
        else $error("free and live counts do not add up to the pool size");

    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fc_reg < SW'(ghal_pkg::SLOTS - 1)))
        else $error("push onto a full free stack");

    a_commit_room : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("result overwritten before it was taken");

    a_create_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_create && create_ok) |-> !tbl_live)
        else $error("create handed out a live slot");

endmodule

// ----- rtl/generational_handle_allocator.sv -----
// Steps from accept to result, set by the registered reads of the slot table
// and free stack RAMs: lookup and remove read the table on accept; create pops
// the free stack on accept, then reads the popped slot's table entry; remove
// all does one table read and one check per slot. Throughput: one item at a
// time; the next is taken the cycle after the result loads, once output is free.
// Reset: asynchronous, active low; per-entry valid bits make both RAMs read as
// their reset contents at once, so there is no clearing pass.
module generational_handle_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ghal_pkg::IN_W-1:0]  s_tdata,   // cmd[1:0], handle_in[17:2]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ghal_pkg::OUT_W-1:0] m_tdata    // status[1:0], handle_out[17:2],
                                                  // slot_out[25:18], live_count[33:26],
                                                  // removed_count[41:34]
);

    ghal_pkg::ghal_cmd_t cmd;
    ghal_pkg::ghal_sts_t sts;

    // sequence each transaction: accept, memory reads, commit into result register
    ghal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot table, free stack, counters and the output register
    ghal_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
